>>> sv/kdj_pkg.sv
// shared constants, types and state codes for the kdj oscillator
package kdj_pkg;

  localparam int WINDOW_MAX    = 64;
  localparam int PRICE_BITS    = 32;
  localparam int FRACTION_BITS = 16;

  localparam int LEN_W   = 7;
  localparam int VALUE_W = 23;
  localparam int J_W     = 26;
  localparam int INDEX_W = 16;

  // 100 * price fits in PRICE_BITS + 7 bits
  localparam int NUM_W  = PRICE_BITS + 7;
  localparam int DV_W   = NUM_W + FRACTION_BITS;
  localparam int REM_W  = PRICE_BITS + 1;
  localparam int STEP_W = $clog2(VALUE_W + 1);

  // divide by three through a reciprocal
  localparam int SUM_W       = VALUE_W + 2;
  localparam int PROD_W      = 2 * SUM_W;
  localparam int RECIP_SHIFT = SUM_W + 1;
  localparam logic [SUM_W-1:0] RECIP_THIRD = SUM_W'((64'd1 << RECIP_SHIFT) / 3);

  localparam int SCAN_W = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

  localparam int IN_DATA_W  = 3 * PRICE_BITS;
  localparam int OUT_DATA_W = ((2 * VALUE_W + J_W + INDEX_W + 7) / 8) * 8;

  localparam logic [VALUE_W-1:0]    FIFTY_FIXED   = VALUE_W'(50 << FRACTION_BITS);
  localparam logic [VALUE_W-1:0]    HUNDRED_FIXED = VALUE_W'(100 << FRACTION_BITS);
  localparam logic [PRICE_BITS-1:0] PRICE_MAX     = '1;
  localparam logic [LEN_W-1:0]      LEN_RESET     = LEN_W'(9);
  localparam logic [LEN_W-1:0]      LEN_MIN       = LEN_W'(2);
  localparam logic [LEN_W-1:0]      LEN_MAX       = LEN_W'(WINDOW_MAX);
  localparam logic [INDEX_W-1:0]    INDEX_TOP     = '1;

  typedef struct packed {
    logic [PRICE_BITS-1:0] hi;
    logic [PRICE_BITS-1:0] lo;
  } bar_pair_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_START,
    S_DIV,
    S_KMUL,
    S_KFIX,
    S_DMUL,
    S_DFIX,
    S_OUT
  } state_t;

endpackage

>>> sv/kdj_cell.sv
// one window cell: a stored bar and one stage of the running max/min
module kdj_cell (
  input  logic               clk,
  input  logic               shift_en,
  input  logic               active,
  input  kdj_pkg::bar_pair_t bar_in,
  output kdj_pkg::bar_pair_t bar_out,
  input  kdj_pkg::bar_pair_t acc_in,
  output kdj_pkg::bar_pair_t acc_out
);
  import kdj_pkg::*;

  bar_pair_t entry;
  bar_pair_t extreme;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= bar_in;
    end
    if (active) begin
      extreme.hi <= (entry.hi > acc_in.hi) ? entry.hi : acc_in.hi;
      extreme.lo <= (entry.lo < acc_in.lo) ? entry.lo : acc_in.lo;
    end else begin
      extreme <= acc_in;
    end
  end

  assign bar_out = entry;
  assign acc_out = extreme;

endmodule

>>> sv/kdj_divider.sv
// restoring divider, one quotient bit per cycle, fixed-point rsv quotient
module kdj_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [kdj_pkg::NUM_W-1:0]      num,
  input  logic [kdj_pkg::PRICE_BITS-1:0] den,
  output logic                           busy,
  output logic                           done,
  output logic [kdj_pkg::VALUE_W-1:0]    quot
);
  import kdj_pkg::*;

  logic [REM_W-1:0]   rem;
  logic [VALUE_W-1:0] qsh;
  logic [STEP_W-1:0]  cnt;
  logic [DV_W-1:0]    dividend;
  logic [REM_W-1:0]   trial;
  logic [REM_W-1:0]   den_ext;
  logic               ge;

  assign dividend = {num, {FRACTION_BITS{1'b0}}};
  assign trial    = {rem[REM_W-2:0], qsh[VALUE_W-1]};
  assign den_ext  = {1'b0, den};
  assign ge       = trial >= den_ext;
  assign done     = busy && (cnt == STEP_W'(1));
  assign quot     = qsh;

  // quotient is known to fit VALUE_W bits, so the upper part starts below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= REM_W'(dividend >> VALUE_W);
      qsh <= dividend[VALUE_W-1:0];
    end else if (busy) begin
      rem <= ge ? (trial - den_ext) : trial;
      qsh <= {qsh[VALUE_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= STEP_W'(VALUE_W);
    end else if (busy) begin
      cnt <= cnt - STEP_W'(1);
      if (cnt == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> sv/kdj_stochastic_oscillator.sv
// top level of the kdj stochastic oscillator: window cells, rsv divider, k/d/j smoothing
//
// usage
//   s_axis carries one price bar per word: tdata holds high, low, close (32 bits
//   each, high in the lowest bits), tuser is the series-start flag. a bar with
//   series start set clears the window history and resets K and D to 50.
//   cfg carries window_length (2..64, out-of-range values clamp); it is always
//   ready and must only be written while the block is idle.
//   m_axis gives one result word per bar once the window is full: K, D, J and
//   the result index in tdata, the flat-window flag in tuser.
// sequencing
//   a bar that yields no result (window not yet full) leaves the block idle and
//   ready for the next bar. a bar with a result is worked through in order: the
//   max/min ripple through the window cells, rsv operand setup, the bit-serial
//   divider (skipped for a flat window), then K/D smoothing and output load on
//   one shared reciprocal multiplier; the next bar goes in once the sequencer is
//   back in idle. s_axis_tready is high only between bars.
// reset and stall
//   rst clears the window count, result index and sets K and D to 50; the
//   window config returns to 9. a result waits in the output register while
//   m_axis_tready is low; the next bar is accepted meanwhile, and its result
//   is held in the sequencer until the output register frees up.
module kdj_stochastic_oscillator (
  input  logic                           clk,
  input  logic                           rst,
  // high [31:0], low [63:32], close [95:64]
  input  logic [kdj_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // series_start [0]
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // k_value [22:0], d_value [45:23], j_value [71:46], output_index [87:72]
  output logic [kdj_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // flat_range [0]
  output logic                           m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [kdj_pkg::LEN_W-1:0]      cfg_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready
);
  import kdj_pkg::*;

  state_t state, state_next;

  // configuration and series bookkeeping
  logic [LEN_W-1:0]   window_length;
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   scan_len;
  logic [CNT_W-1:0]   bars_seen;
  logic [CNT_W-1:0]   bars_base;
  logic [CNT_W-1:0]   bars_seen_next;
  logic [INDEX_W-1:0] result_count;
  logic [VALUE_W-1:0] previous_k;
  logic [VALUE_W-1:0] previous_d;
  logic [SCAN_W-1:0]  scan_cnt;

  logic in_accept;
  logic series_start;
  logic want_result;
  logic shift_en;
  logic div_start;
  logic out_free;

  // bar close and rsv operands
  logic [PRICE_BITS-1:0] close_reg;
  logic [PRICE_BITS-1:0] highest;
  logic [PRICE_BITS-1:0] lowest;
  logic [PRICE_BITS-1:0] close_clamp;
  logic [PRICE_BITS-1:0] span;
  logic [NUM_W-1:0]      span_ext;
  logic [NUM_W-1:0]      num_reg;
  logic [PRICE_BITS-1:0] den_reg;
  logic                  flat;

  logic               div_busy;
  logic               div_done;
  logic [VALUE_W-1:0] div_quot;
  logic [VALUE_W-1:0] rsv;

  // shared divide-by-three
  logic [SUM_W-1:0]   x_in;
  logic [SUM_W-1:0]   x_reg;
  logic [PROD_W-1:0]  prod_reg;
  logic [SUM_W-1:0]   q_est;
  logic [SUM_W-1:0]   q_rem;
  logic [SUM_W-1:0]   q_fix;
  logic [VALUE_W-1:0] k_reg;
  logic [VALUE_W-1:0] d_reg;
  logic [J_W-1:0]     j_calc;

  // output register
  logic [VALUE_W-1:0] out_k;
  logic [VALUE_W-1:0] out_d;
  logic [J_W-1:0]     out_j;
  logic [INDEX_W-1:0] out_index;
  logic               out_flat;

  // window cells
  bar_pair_t              new_bar;
  bar_pair_t              acc_seed;
  bar_pair_t              cell_bar [WINDOW_MAX];
  bar_pair_t              cell_acc [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  cell_active;

  assign cfg_ready    = 1'b1;
  assign in_accept    = s_axis_tvalid && s_axis_tready;
  assign series_start = s_axis_tuser;

  // clamp the configured length into 2..WINDOW_MAX
  always_comb begin
    if (window_length < LEN_MIN) begin
      len_eff = LEN_MIN;
    end else if (window_length > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = window_length;
    end
  end

  // bar count after this bar is taken, saturating at the window depth
  always_comb begin
    bars_base = series_start ? '0 : bars_seen;
    if (bars_base < CNT_W'(WINDOW_MAX)) begin
      bars_seen_next = bars_base + CNT_W'(1);
    end else begin
      bars_seen_next = bars_base;
    end
  end

  assign want_result = CNT_W'(bars_seen_next) >= CNT_W'(len_eff);

  // ---------------------------------------------------------------------------
  // row of window cells: newest bar at cell 0, max/min ripples one cell a cycle
  // ---------------------------------------------------------------------------
  assign new_bar.hi  = s_axis_tdata[PRICE_BITS-1:0];
  assign new_bar.lo  = s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS];
  assign acc_seed.hi = '0;
  assign acc_seed.lo = PRICE_MAX;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    assign cell_active[i] = CNT_W'(i) < CNT_W'(scan_len);
    if (i == 0) begin : g_head
      kdj_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .active   (cell_active[i]),
        .bar_in   (new_bar),
        .bar_out  (cell_bar[i]),
        .acc_in   (acc_seed),
        .acc_out  (cell_acc[i])
      );
    end else begin : g_body
      kdj_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .active   (cell_active[i]),
        .bar_in   (cell_bar[i-1]),
        .bar_out  (cell_bar[i]),
        .acc_in   (cell_acc[i-1]),
        .acc_out  (cell_acc[i])
      );
    end
  end

  assign highest = cell_acc[WINDOW_MAX-1].hi;
  assign lowest  = cell_acc[WINDOW_MAX-1].lo;

  // close clamped into [lowest, highest]; only meaningful when not flat
  always_comb begin
    if (close_reg < lowest) begin
      close_clamp = lowest;
    end else if (close_reg > highest) begin
      close_clamp = highest;
    end else begin
      close_clamp = close_reg;
    end
  end

  assign span     = close_clamp - lowest;
  assign span_ext = NUM_W'(span);

  // ---------------------------------------------------------------------------
  // rsv divider
  // ---------------------------------------------------------------------------
  kdj_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_reg),
    .den   (den_reg),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign rsv = flat ? FIFTY_FIXED : div_quot;

  // ---------------------------------------------------------------------------
  // floor(x/3) as reciprocal multiply, then one correction step
  // ---------------------------------------------------------------------------
  always_comb begin
    if (state == S_KMUL) begin
      x_in = SUM_W'({previous_k, 1'b0}) + SUM_W'(rsv);
    end else begin
      x_in = SUM_W'({previous_d, 1'b0}) + SUM_W'(k_reg);
    end
  end

  assign q_est = SUM_W'(prod_reg[PROD_W-1:RECIP_SHIFT]);
  assign q_rem = x_reg - ((q_est << 1) + q_est);
  assign q_fix = (q_rem >= SUM_W'(3)) ? (q_est + SUM_W'(1)) : q_est;

  // J = 3D - 2K, wraps into two's complement
  assign j_calc = ((J_W'(d_reg) << 1) + J_W'(d_reg)) - (J_W'(k_reg) << 1);

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && want_result) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == SCAN_W'(WINDOW_MAX - 1)) begin
          state_next = S_PREP;
        end
      end
      S_PREP:  state_next = S_START;
      S_START: state_next = flat ? S_KMUL : S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_KMUL;
        end
      end
      S_KMUL:  state_next = S_KFIX;
      S_KFIX:  state_next = S_DMUL;
      S_DMUL:  state_next = S_DFIX;
      S_DFIX:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    unique case (state)
      S_IDLE:  s_axis_tready = 1'b1;
      S_START: div_start = !flat;
      default: begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
      end
    endcase
  end

  assign shift_en = in_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= LEN_RESET;
      bars_seen     <= '0;
      result_count  <= '0;
      previous_k    <= FIFTY_FIXED;
      previous_d    <= FIFTY_FIXED;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        window_length <= cfg_data;
      end
      if (in_accept) begin
        bars_seen <= bars_seen_next;
        if (series_start) begin
          result_count <= '0;
          previous_k   <= FIFTY_FIXED;
          previous_d   <= FIFTY_FIXED;
        end
      end
      if (state == S_KFIX) begin
        previous_k <= VALUE_W'(q_fix);
      end
      if (state == S_DFIX) begin
        previous_d <= VALUE_W'(q_fix);
      end
      if (state == S_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
        if (result_count != INDEX_TOP) begin
          result_count <= result_count + INDEX_W'(1);
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      close_reg <= s_axis_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
      scan_len  <= len_eff;
      scan_cnt  <= '0;
    end else if (state == S_SCAN) begin
      scan_cnt <= scan_cnt + SCAN_W'(1);
    end
    if (state == S_PREP) begin
      flat    <= highest <= lowest;
      den_reg <= highest - lowest;
      // 100 * span as 64 + 32 + 4
      num_reg <= (span_ext << 6) + (span_ext << 5) + (span_ext << 2);
    end
    if (state == S_KMUL || state == S_DMUL) begin
      x_reg    <= x_in;
      prod_reg <= PROD_W'(x_in) * PROD_W'(RECIP_THIRD);
    end
    if (state == S_KFIX) begin
      k_reg <= VALUE_W'(q_fix);
    end
    if (state == S_DFIX) begin
      d_reg <= VALUE_W'(q_fix);
    end
    if (state == S_OUT && out_free) begin
      out_k     <= k_reg;
      out_d     <= d_reg;
      out_j     <= j_calc;
      out_index <= result_count;
      out_flat  <= flat;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[VALUE_W-1:0]                           = out_k;
    m_axis_tdata[2*VALUE_W-1:VALUE_W]                   = out_d;
    m_axis_tdata[2*VALUE_W+J_W-1:2*VALUE_W]             = out_j;
    m_axis_tdata[2*VALUE_W+J_W+INDEX_W-1:2*VALUE_W+J_W] = out_index;
  end

  assign m_axis_tuser = out_flat;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_no_result_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !want_result) |=> (state == S_IDLE))
    else $error("bar without result left the idle state");

  a_idle_divider_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_busy)
    else $error("divider busy while taking a new bar");

  a_kd_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_k <= HUNDRED_FIXED) && (out_d <= HUNDRED_FIXED)))
    else $error("k or d above 100");

endmodule
